// ----- rtl/core/assert_macros.svh -----
// assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rgb2hsv_pkg.sv -----
package rgb2hsv_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned HueW      = 15;
  localparam int unsigned SatW      = 16;
  localparam int unsigned NumW      = 24;
  localparam int unsigned DivSteps  = 5;
  localparam int unsigned DivStages = 4;
  localparam int unsigned QuoBits   = DivSteps * DivStages;
  localparam int unsigned IdxW      = $clog2(NumW);

  localparam logic [HueW-1:0] HueTurn        = 15'd23040;
  localparam logic [11:0]     HueSixth       = 12'd3840;
  localparam logic [11:0]     SectorsPerTurn = 12'd6;

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  typedef struct packed {
    logic [ChanW-1:0]   rem;
    logic [QuoBits-1:0] quo;
    logic [NumW-1:0]    num;
    logic [ChanW-1:0]   den;
  } div_lane_t;

  typedef struct packed {
    div_lane_t sat;
    div_lane_t hue;
  } div_stage_t;

  // one restoring division step, quotient bit b
  function automatic div_lane_t lane_step(input div_lane_t l, input logic [IdxW-1:0] b);
    logic [ChanW:0] t;
    div_lane_t      o;
    o = l;
    t = {l.rem, l.num[b]};
    if (t >= {1'b0, l.den}) begin
      o.rem    = ChanW'(t - {1'b0, l.den});
      o.quo[b] = 1'b1;
    end else begin
      o.rem = t[ChanW-1:0];
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/rgb2hsv_pix_if.sv -----
interface rgb2hsv_pix_if;
  import rgb2hsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/core/rgb2hsv_hsv_if.sv -----
interface rgb2hsv_hsv_if;
  import rgb2hsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [SatW-1:0]  saturation;
  logic [ChanW-1:0] value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

// ----- rtl/core/rgb_to_hsv.sv -----
// rgb_to_hsv: 8-bit rgb pixel in, hue / saturation / value out
// pipeline: min/max, hue setup, four stages of a 20-step restoring divider at
// 5 steps each, output register
// throughput: one item per cycle; each stage holds only while its successor is full
// reset: rst_ni asynchronous active low clears all valid bits; data registers are not reset
`include "assert_macros.svh"

module rgb_to_hsv import rgb2hsv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rgb2hsv_pix_if.sink          pix_i,
  rgb2hsv_hsv_if.source        hsv_o
);

  localparam int unsigned NumStages = DivStages + 3;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  // stage enables: a stage loads when it is empty or its successor moves on
  always_comb begin
    en[NumStages-1] = ~v_q[NumStages-1] | hsv_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: max, min, sector
  logic [ChanW-1:0]       hi_d, lo_d;
  sector_e                sec_d;
  logic signed [ChanW:0]  num_d;
  logic [ChanW-1:0]       s1_hi_q, s1_delta_q;
  sector_e                s1_sec_q;
  logic signed [ChanW:0]  s1_num_q;

  always_comb begin
    hi_d = pix_i.red;
    lo_d = pix_i.red;
    if (pix_i.green > hi_d) hi_d = pix_i.green;
    if (pix_i.blue > hi_d)  hi_d = pix_i.blue;
    if (pix_i.green < lo_d) lo_d = pix_i.green;
    if (pix_i.blue < lo_d)  lo_d = pix_i.blue;
    if (pix_i.red >= hi_d) begin
      sec_d = SecRed;
      num_d = $signed({1'b0, pix_i.green}) - $signed({1'b0, pix_i.blue});
    end else if (pix_i.green >= hi_d) begin
      sec_d = SecGreen;
      num_d = $signed({1'b0, pix_i.blue}) - $signed({1'b0, pix_i.red});
    end else begin
      sec_d = SecBlue;
      num_d = $signed({1'b0, pix_i.red}) - $signed({1'b0, pix_i.green});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_hi_q    <= hi_d;
      s1_delta_q <= hi_d - lo_d;
      s1_sec_q   <= sec_d;
      s1_num_q   <= num_d;
    end
  end

  // stage 2: dividends for both quotients, then divider stages
  logic signed [11:0] t_d;
  logic [10:0]        tt_d;
  logic [22:0]        un_d;
  div_stage_t         dv_d [DivStages+1];
  div_stage_t         dv_q [DivStages+1];
  div_stage_t         cur;

  always_comb begin
    case (s1_sec_q)
      SecRed:   t_d = 12'(s1_num_q);
      SecGreen: t_d = $signed({3'b000, s1_delta_q, 1'b0}) + 12'(s1_num_q);
      SecBlue:  t_d = $signed({2'b00, s1_delta_q, 2'b00}) + 12'(s1_num_q);
      default:  t_d = 12'(s1_num_q);
    endcase
    // negative red-sector hue wraps by a full turn
    if (t_d < 0) begin
      tt_d = 11'($unsigned(t_d) + 12'(s1_delta_q) * SectorsPerTurn);
    end else begin
      tt_d = 11'($unsigned(t_d));
    end
    un_d = 23'(tt_d) * 23'(HueSixth);

    dv_d[0].sat.num = {s1_delta_q, 16'h0000} + NumW'(s1_hi_q[ChanW-1:1]);
    dv_d[0].sat.den = s1_hi_q;
    dv_d[0].sat.quo = '0;
    dv_d[0].sat.rem = ChanW'(dv_d[0].sat.num[NumW-1:QuoBits]);
    dv_d[0].hue.num = NumW'(un_d) + NumW'(s1_delta_q[ChanW-1:1]);
    dv_d[0].hue.den = s1_delta_q;
    dv_d[0].hue.quo = '0;
    dv_d[0].hue.rem = ChanW'(dv_d[0].hue.num[NumW-1:QuoBits]);

    for (int j = 1; j <= DivStages; j++) begin
      cur = dv_q[j-1];
      for (int s = 0; s < DivSteps; s++) begin
        cur.sat = lane_step(cur.sat, IdxW'(QuoBits - 1 - ((j - 1) * DivSteps + s)));
        cur.hue = lane_step(cur.hue, IdxW'(QuoBits - 1 - ((j - 1) * DivSteps + s)));
      end
      dv_d[j] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= DivStages; j++) begin
      if (en[j+1]) begin
        dv_q[j] <= dv_d[j];
      end
    end
  end

  // output stage: clamp, wrap, gray override
  logic                gray;
  logic [QuoBits-1:0]  qs, qh;
  logic [HueW-1:0]     hue_d, hue_q;
  logic [SatW-1:0]     sat_d, sat_q;
  logic [ChanW-1:0]    val_q;

  always_comb begin
    qs   = dv_q[DivStages].sat.quo;
    qh   = dv_q[DivStages].hue.quo;
    gray = (dv_q[DivStages].hue.den == '0);
    if (gray) begin
      sat_d = '0;
      hue_d = '0;
    end else begin
      sat_d = (|qs[QuoBits-1:SatW]) ? '1 : qs[SatW-1:0];
      if (qh >= QuoBits'(HueTurn)) begin
        hue_d = HueW'(qh - QuoBits'(HueTurn));
      end else begin
        hue_d = HueW'(qh);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= dv_q[DivStages].sat.den;
    end
  end

  assign hsv_o.valid      = v_q[NumStages-1];
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.value      = val_q;

  `ASSERT_CLK(a_hue_range, hsv_o.valid |-> (hsv_o.hue < HueTurn), "hue beyond a full turn")
  `ASSERT_CLK(a_gray_hue, (hsv_o.valid && (hsv_o.saturation == '0)) |-> (hsv_o.hue == '0),
              "zero saturation with nonzero hue")
  `ASSERT_CLK(a_div_rem, (v_q[NumStages-2] && (dv_q[DivStages].hue.den != '0)) |->
              ((dv_q[DivStages].hue.rem < dv_q[DivStages].hue.den) &&
               (dv_q[DivStages].sat.rem < dv_q[DivStages].sat.den)),
              "divider remainder not below divisor")
  `ASSERT_NEXT(a_take, pix_i.valid && pix_i.ready, v_q[0], "accepted item not captured")

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import rgb2hsv_pkg::*;

  typedef struct {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    int unsigned      gap;
    bit               drain;
  } pixel_t;

  typedef struct {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] value;
  } hsv_t;

  logic clk_i;
  logic rst_ni;

  rgb2hsv_pix_if pix ();
  rgb2hsv_hsv_if hsv ();

  rgb_to_hsv uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .hsv_o  (hsv)
  );

  pixel_t      pixels_pending[$];
  hsv_t        hsv_expected[$];
  pixel_t      next_pixel;
  hsv_t        want_hsv;
  int unsigned gap_left;
  bit          gap_loaded;
  int unsigned stall_left;
  bit          sink_fast;
  int unsigned error_count;
  int unsigned pixels_sent;
  int unsigned results_checked;
  int unsigned gray_seen;
  int unsigned full_sat_seen;
  int unsigned sector_seen[3];

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic hsv_t convert_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                         logic [ChanW-1:0] b);
    hsv_t        res;
    int unsigned hi;
    int unsigned lo;
    int unsigned delta;
    int unsigned sat;
    int unsigned hue;
    int          diff;
    int          angle;
    sector_e     sec;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    sat = 0;
    hue = 0;
    if (delta != 0) begin
      sat = (delta * 131072 + hi) / (2 * hi);
      if (sat > 65535) sat = 65535;
      if (r >= hi) begin
        sec = SecRed;
        diff = int'(g) - int'(b);
      end else if (g >= hi) begin
        sec = SecGreen;
        diff = int'(b) - int'(r);
      end else begin
        sec = SecBlue;
        diff = int'(r) - int'(g);
      end
      angle = 3840 * (2 * int'(sec) * int'(delta) + diff);
      if (angle < 0) angle += 23040 * int'(delta);
      hue = (2 * unsigned'(angle) + delta) / (2 * delta);
      if (hue >= 23040) hue -= 23040;
    end
    res.hue        = hue[HueW-1:0];
    res.saturation = sat[SatW-1:0];
    res.value      = hi[ChanW-1:0];
    return res;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      gap_left = 0;
      gap_loaded = 1'b0;
    end else if (!pix.valid || pix.ready) begin
      if (pix.valid) begin
        want_hsv = convert_pixel(pix.red, pix.green, pix.blue);
        hsv_expected.push_back(want_hsv);
        pixels_sent++;
        if (want_hsv.saturation == 0) gray_seen++;
        if (want_hsv.saturation == 16'hFFFF) full_sat_seen++;
        if (want_hsv.saturation != 0) begin
          if (pix.red == want_hsv.value) sector_seen[SecRed]++;
          else if (pix.green == want_hsv.value) sector_seen[SecGreen]++;
          else sector_seen[SecBlue]++;
        end
      end
      if (!gap_loaded && pixels_pending.size() != 0) begin
        gap_left = pixels_pending[0].gap;
        gap_loaded = 1'b1;
      end
      if (gap_left != 0) begin
        gap_left--;
        pix.valid <= 1'b0;
      end else if (pixels_pending.size() == 0 ||
                   (pixels_pending[0].drain && hsv_expected.size() != 0)) begin
        pix.valid <= 1'b0;
      end else begin
        next_pixel = pixels_pending.pop_front();
        gap_loaded = 1'b0;
        pix.red   <= next_pixel.red;
        pix.green <= next_pixel.green;
        pix.blue  <= next_pixel.blue;
        pix.valid <= 1'b1;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsv.ready <= 1'b0;
      stall_left = 0;
      sink_fast = 1'b0;
    end else begin
      if (hsv.valid && hsv.ready) begin
        if (hsv_expected.size() == 0) begin
          flag_error("result with no pixel outstanding");
        end else begin
          want_hsv = hsv_expected.pop_front();
          if (hsv.hue !== want_hsv.hue)
            flag_error($sformatf("hue %0d, expected %0d", hsv.hue, want_hsv.hue));
          if (hsv.saturation !== want_hsv.saturation)
            flag_error($sformatf("saturation %0d, expected %0d", hsv.saturation,
                                 want_hsv.saturation));
          if (hsv.value !== want_hsv.value)
            flag_error($sformatf("value %0d, expected %0d", hsv.value, want_hsv.value));
        end
        results_checked++;
        if (results_checked % 64 == 0) sink_fast = ($urandom_range(0, 3) == 0);
        stall_left = sink_fast ? 0 : $urandom_range(0, 13);
      end
      if (stall_left != 0) begin
        stall_left--;
        hsv.ready <= 1'b0;
      end else begin
        hsv.ready <= 1'b1;
      end
    end
  end

  task automatic queue_pixel(input int r, input int g, input int b, input int unsigned gap,
                             input bit drain);
    pixel_t p;
    p.red   = r[ChanW-1:0];
    p.green = g[ChanW-1:0];
    p.blue  = b[ChanW-1:0];
    p.gap   = gap;
    p.drain = drain;
    pixels_pending.push_back(p);
  endtask

  function automatic int near(input int c, input int spread);
    int v;
    v = c + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  task automatic queue_random(input int unsigned gap, input bit drain);
    int kind;
    int c;
    kind = $urandom_range(0, 9);
    c = $urandom_range(0, 255);
    case (kind)
      0, 1: begin
        // near gray, small delta
        queue_pixel(near(c, 3), near(c, 3), near(c, 3), gap, drain);
      end
      2: begin
        // one channel at zero
        case ($urandom_range(0, 2))
          0: queue_pixel(0, $urandom_range(0, 255), $urandom_range(0, 255), gap, drain);
          1: queue_pixel($urandom_range(0, 255), 0, $urandom_range(0, 255), gap, drain);
          default: queue_pixel($urandom_range(0, 255), $urandom_range(0, 255), 0, gap, drain);
        endcase
      end
      3: begin
        // two channels tied
        case ($urandom_range(0, 2))
          0: queue_pixel(c, c, $urandom_range(0, 255), gap, drain);
          1: queue_pixel($urandom_range(0, 255), c, c, gap, drain);
          default: queue_pixel(c, $urandom_range(0, 255), c, gap, drain);
        endcase
      end
      4: begin
        // red largest, blue at or above green
        queue_pixel(255 - $urandom_range(0, 40), near(20, 20), near(60, 20), gap, drain);
      end
      default: begin
        queue_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    gap, drain);
      end
    endcase
  endtask

  initial begin
    int unsigned gap;
    bit          burst;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    hsv.ready = 1'b0;
    rst_ni    = 1'b0;
    error_count = 0;
    pixels_sent = 0;
    results_checked = 0;
    gray_seen = 0;
    full_sat_seen = 0;
    sector_seen = '{default: 0};

    // extremes, sectors, ties, wrap, full saturation, bit patterns
    queue_pixel(0, 0, 0, 0, 0);
    queue_pixel(255, 255, 255, 0, 0);
    queue_pixel(128, 128, 128, 1, 0);
    queue_pixel(255, 0, 0, 0, 0);
    queue_pixel(0, 255, 0, 0, 0);
    queue_pixel(0, 0, 255, 0, 0);
    queue_pixel(255, 255, 0, 2, 0);
    queue_pixel(0, 255, 255, 0, 0);
    queue_pixel(255, 0, 255, 0, 0);
    queue_pixel(255, 0, 1, 0, 0);
    queue_pixel(255, 254, 255, 0, 0);
    queue_pixel(200, 10, 150, 3, 0);
    queue_pixel(1, 0, 0, 0, 0);
    queue_pixel(1, 0, 1, 0, 0);
    queue_pixel(0, 1, 0, 0, 0);
    queue_pixel(255, 254, 254, 0, 0);
    queue_pixel(85, 170, 85, 0, 0);
    queue_pixel(170, 85, 170, 5, 0);
    queue_pixel(254, 255, 253, 0, 0);
    queue_pixel(100, 101, 255, 0, 0);
    queue_pixel(3, 2, 1, 0, 0);
    queue_pixel(1, 2, 3, 13, 0);

    burst = 1'b0;
    for (int i = 0; i < 1100; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 13);
      queue_random(gap, (i == 0) || (i == 600));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pixels_pending.size() != 0 || pix.valid || hsv_expected.size() != 0);
    repeat (20) @(posedge clk_i);
    if (hsv_expected.size() != 0)
      flag_error($sformatf("%0d results never arrived", hsv_expected.size()));

    $display("%0d pixels converted and %0d results compared", pixels_sent, results_checked);
    $display("gray %0d, full saturation %0d, red/green/blue peaks %0d/%0d/%0d",
             gray_seen, full_sat_seen, sector_seen[SecRed], sector_seen[SecGreen],
             sector_seen[SecBlue]);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout waiting for results");
    $display("tb failed");
    $finish;
  end

endmodule
